// ===== hw/rtl/lca_pkg.sv =====
package lca_pkg;

    localparam int NODE_W   = 10;
    localparam int DEPTH_W  = 10;
    localparam int DIST_W   = 11;
    localparam int ACT_W    = 2;
    localparam int CNT_W    = 10;
    localparam int LOG_W    = 4;
    localparam int DIST_MAX = 2047;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef struct packed {
        logic sub;
        logic dbl_b;
    } alu_ctl_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

    // signed width of the shared unit: room for depth gaps less 2^LEVELS
    function automatic int alu_width(input int levels);
        return ((levels + 2) > 13) ? (levels + 2) : 13;
    endfunction

    // index of the highest set bit; zero input gives zero
    function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (x[i])
            begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/lca_ram.sv =====
module lca_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 10,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lca_alu.sv =====
module lca_alu #(
    parameter int W = 13
) (
    input  lca_pkg::alu_ctl_t   ctl,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] res,
    output lca_pkg::alu_flags_t flags
);

    logic signed [W-1:0] b_eff;

    assign b_eff      = ctl.dbl_b ? (b <<< 1) : b;
    assign res        = ctl.sub ? (a - b_eff) : (a + b_eff);
    assign flags.neg  = res[W-1];
    assign flags.zero = (res == '0);

endmodule

// ===== hw/rtl/lca_seq.sv =====
module lca_seq #(
    parameter int MAX_NODES = 1023,
    parameter int LEVELS    = 10,
    localparam int ROWS     = MAX_NODES + 1,
    localparam int COLS     = LEVELS + 1,
    localparam int TOTAL    = ROWS * COLS,
    localparam int AW       = $clog2(ROWS),
    localparam int JW       = $clog2(TOTAL),
    localparam int LVW      = $clog2(COLS),
    localparam int SW       = lca_pkg::alu_width(LEVELS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lca_pkg::ACT_W-1:0]     action,
    input  logic [lca_pkg::NODE_W-1:0]    node_a,
    input  logic [lca_pkg::NODE_W-1:0]    node_b,
    input  logic [lca_pkg::DEPTH_W-1:0]   node_depth,
    input  logic [lca_pkg::CNT_W-1:0]     node_count,
    output logic                          busy,
    output logic                          done,
    output logic [lca_pkg::NODE_W-1:0]    ancestor,
    output logic [lca_pkg::DIST_W-1:0]    distance,
    output logic                          jt_we,
    output logic [JW-1:0]                 jt_waddr,
    output logic [lca_pkg::NODE_W-1:0]    jt_wdata,
    output logic [JW-1:0]                 jt_raddr,
    input  logic [lca_pkg::NODE_W-1:0]    jt_rdata,
    output logic                          dp_we,
    output logic [AW-1:0]                 dp_waddr,
    output logic [lca_pkg::DEPTH_W-1:0]   dp_wdata,
    output logic [AW-1:0]                 dp_raddr,
    input  logic [lca_pkg::DEPTH_W-1:0]   dp_rdata,
    output lca_pkg::alu_ctl_t             alu_ctl,
    output logic signed [SW-1:0]          alu_a,
    output logic signed [SW-1:0]          alu_b,
    input  logic signed [SW-1:0]          alu_res,
    input  lca_pkg::alu_flags_t           alu_flags
);

    localparam int NW = lca_pkg::NODE_W;
    localparam int XW = (AW > NW) ? AW : NW;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_B_RD2,
        S_B_WR,
        S_Q_DB,
        S_Q_ORD,
        S_Q_SUM,
        S_Q_GAP,
        S_L1_CMP,
        S_L1_JMP,
        S_L1_DEP,
        S_EQ,
        S_P2_RA,
        S_P2_RB,
        S_P2_CMP,
        S_A_GET,
        S_A_DEP
    } state_t;

    state_t                          state_reg, state_next;
    logic [JW-1:0]                   clr_reg, clr_next;
    logic [lca_pkg::CNT_W-1:0]       i_reg, i_next;
    logic [lca_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [LVW-1:0]                  j_reg, j_next;
    logic [LVW-1:0]                  top_reg, top_next;
    logic [LVW-1:0]                  lvl_reg, lvl_next;
    logic [LVW-1:0]                  k_reg, k_next;
    logic [NW-1:0]                   u_reg, u_next;
    logic [NW-1:0]                   v_reg, v_next;
    logic [NW-1:0]                   pu_reg, pu_next;
    logic [NW-1:0]                   anc_reg, anc_next;
    logic [lca_pkg::DEPTH_W-1:0]     du_reg, du_next;
    logic [lca_pkg::DEPTH_W-1:0]     dv_reg, dv_next;
    logic signed [SW-1:0]            gap_reg, gap_next;
    logic signed [SW-1:0]            sum_reg, sum_next;
    logic                            flat_reg, flat_next;
    logic                            done_reg, done_next;
    logic [NW-1:0]                   ancestor_reg, ancestor_next;
    logic [lca_pkg::DIST_W-1:0]      distance_reg, distance_next;

    logic [NW-1:0]                   a_cl;
    logic [NW-1:0]                   b_cl;
    logic [lca_pkg::CNT_W-1:0]       n_cur;
    logic                            take;

    function automatic logic [AW-1:0] row(input logic [NW-1:0] n);
        logic [XW-1:0] x;
        x = XW'(n);
        return x[AW-1:0];
    endfunction

    function automatic logic [NW-1:0] clamp_node(input logic [NW-1:0] n);
        logic [XW-1:0] x;
        x = XW'(n);
        return (x > XW'(MAX_NODES)) ? '0 : n;
    endfunction

    // table laid out level-major: level * ROWS + node
    function automatic logic [JW-1:0] jt_addr(input logic [LVW-1:0] lvl,
                                              input logic [NW-1:0] n);
        return JW'(lvl) * JW'(ROWS) + JW'(row(n));
    endfunction

    function automatic logic [LVW-1:0] cap_level(input logic [lca_pkg::LOG_W-1:0] fl);
        if (int'(fl) > LEVELS)
        begin
            return LVW'(LEVELS);
        end
        return LVW'(fl);
    endfunction

    assign a_cl  = clamp_node(node_a);
    assign b_cl  = clamp_node(node_b);
    assign n_cur = (XW'(node_count) > XW'(MAX_NODES)) ? lca_pkg::CNT_W'(MAX_NODES)
                                                      : node_count;
    assign take  = (pu_reg != '0) && !alu_flags.zero;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        top_next      = top_reg;
        lvl_next      = lvl_reg;
        k_next        = k_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        pu_next       = pu_reg;
        anc_next      = anc_reg;
        du_next       = du_reg;
        dv_next       = dv_reg;
        gap_next      = gap_reg;
        sum_next      = sum_reg;
        flat_next     = flat_reg;
        done_next     = 1'b0;
        ancestor_next = ancestor_reg;
        distance_next = distance_reg;

        jt_we         = 1'b0;
        jt_waddr      = '0;
        jt_wdata      = '0;
        jt_raddr      = '0;
        dp_we         = 1'b0;
        dp_waddr      = '0;
        dp_wdata      = '0;
        dp_raddr      = '0;
        alu_ctl.sub   = 1'b1;
        alu_ctl.dbl_b = 1'b0;
        alu_a         = '0;
        alu_b         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                jt_we    = 1'b1;
                jt_waddr = clr_reg;
                dp_we    = (clr_reg < JW'(ROWS));
                dp_waddr = clr_reg[AW-1:0];
                if (clr_reg == JW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        lca_pkg::ACT_LOAD:
                        begin
                            if (a_cl != '0)
                            begin
                                jt_we    = 1'b1;
                                jt_waddr = jt_addr('0, a_cl);
                                jt_wdata = b_cl;
                                dp_we    = 1'b1;
                                dp_waddr = row(a_cl);
                                dp_wdata = node_depth;
                            end
                        end
                        lca_pkg::ACT_BUILD:
                        begin
                            // fewer than two nodes leaves no level above 0
                            if (n_cur > lca_pkg::CNT_W'(1))
                            begin
                                n_next     = n_cur;
                                top_next   = cap_level(lca_pkg::floor_log2(n_cur));
                                j_next     = LVW'(1);
                                i_next     = lca_pkg::CNT_W'(1);
                                jt_raddr   = jt_addr('0, NW'(1));
                                state_next = S_B_RD2;
                            end
                        end
                        lca_pkg::ACT_QUERY:
                        begin
                            u_next     = a_cl;
                            v_next     = b_cl;
                            dp_raddr   = row(a_cl);
                            state_next = S_Q_DB;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_B_RD2:
            begin
                jt_raddr   = jt_addr(LVW'(j_reg - 1'b1), jt_rdata);
                state_next = S_B_WR;
            end

            S_B_WR:
            begin
                jt_we      = 1'b1;
                jt_waddr   = jt_addr(j_reg, i_reg);
                jt_wdata   = jt_rdata;
                state_next = S_B_RD2;
                if (i_reg == n_reg)
                begin
                    if (j_reg == top_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next   = LVW'(j_reg + 1'b1);
                        i_next   = lca_pkg::CNT_W'(1);
                        jt_raddr = jt_addr(j_reg, NW'(1));
                    end
                end
                else
                begin
                    i_next   = lca_pkg::CNT_W'(i_reg + 1'b1);
                    jt_raddr = jt_addr(LVW'(j_reg - 1'b1), NW'(i_reg + 1'b1));
                end
            end

            S_Q_DB:
            begin
                du_next    = dp_rdata;
                dp_raddr   = row(v_reg);
                state_next = S_Q_ORD;
            end

            S_Q_ORD:
            begin
                alu_a = SW'(du_reg);
                alu_b = SW'(dp_rdata);
                // deeper node goes to u
                if (alu_flags.neg)
                begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    du_next = dp_rdata;
                    dv_next = du_reg;
                end
                else
                begin
                    dv_next = dp_rdata;
                end
                state_next = S_Q_SUM;
            end

            S_Q_SUM:
            begin
                alu_ctl.sub = 1'b0;
                alu_a       = SW'(du_reg);
                alu_b       = SW'(dv_reg);
                sum_next    = alu_res;
                state_next  = S_Q_GAP;
            end

            S_Q_GAP:
            begin
                alu_a     = SW'(du_reg);
                alu_b     = SW'(dv_reg);
                gap_next  = alu_res;
                k_next    = cap_level(lca_pkg::floor_log2(du_reg));
                lvl_next  = cap_level(lca_pkg::floor_log2(du_reg));
                flat_next = (du_reg == '0);
                state_next = (du_reg == '0) ? S_EQ : S_L1_CMP;
            end

            S_L1_CMP:
            begin
                alu_a = gap_reg;
                alu_b = {{(SW - 1){1'b0}}, 1'b1} << lvl_reg;
                if (!alu_flags.neg)
                begin
                    jt_raddr   = jt_addr(lvl_reg, u_reg);
                    state_next = S_L1_JMP;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = S_EQ;
                end
                else
                begin
                    lvl_next = LVW'(lvl_reg - 1'b1);
                end
            end

            S_L1_JMP:
            begin
                u_next     = jt_rdata;
                dp_raddr   = row(jt_rdata);
                state_next = S_L1_DEP;
            end

            S_L1_DEP:
            begin
                // gap follows the stored depth of the node reached
                alu_a    = SW'(dp_rdata);
                alu_b    = SW'(dv_reg);
                gap_next = alu_res;
                if (lvl_reg == '0)
                begin
                    state_next = S_EQ;
                end
                else
                begin
                    lvl_next   = LVW'(lvl_reg - 1'b1);
                    state_next = S_L1_CMP;
                end
            end

            S_EQ:
            begin
                alu_a = SW'(u_reg);
                alu_b = SW'(v_reg);
                if (alu_flags.zero)
                begin
                    anc_next   = u_reg;
                    dp_raddr   = row(u_reg);
                    state_next = S_A_DEP;
                end
                else if (flat_reg)
                begin
                    jt_raddr   = jt_addr('0, u_reg);
                    state_next = S_A_GET;
                end
                else
                begin
                    lvl_next   = k_reg;
                    jt_raddr   = jt_addr(k_reg, u_reg);
                    state_next = S_P2_RB;
                end
            end

            S_P2_RA:
            begin
                jt_raddr   = jt_addr(lvl_reg, u_reg);
                state_next = S_P2_RB;
            end

            S_P2_RB:
            begin
                pu_next    = jt_rdata;
                jt_raddr   = jt_addr(lvl_reg, v_reg);
                state_next = S_P2_CMP;
            end

            S_P2_CMP:
            begin
                alu_a = SW'(pu_reg);
                alu_b = SW'(jt_rdata);
                if (take)
                begin
                    u_next = pu_reg;
                    v_next = jt_rdata;
                end
                if (lvl_reg == '0)
                begin
                    jt_raddr   = jt_addr('0, take ? pu_reg : u_reg);
                    state_next = S_A_GET;
                end
                else
                begin
                    lvl_next   = LVW'(lvl_reg - 1'b1);
                    state_next = S_P2_RA;
                end
            end

            S_A_GET:
            begin
                anc_next   = jt_rdata;
                dp_raddr   = row(jt_rdata);
                state_next = S_A_DEP;
            end

            S_A_DEP:
            begin
                alu_ctl.dbl_b = 1'b1;
                alu_a         = sum_reg;
                alu_b         = SW'(dp_rdata);
                done_next     = 1'b1;
                ancestor_next = anc_reg;
                if (alu_flags.neg)
                begin
                    distance_next = '0;
                end
                else if (alu_res > SW'(lca_pkg::DIST_MAX))
                begin
                    distance_next = lca_pkg::DIST_W'(lca_pkg::DIST_MAX);
                end
                else
                begin
                    distance_next = alu_res[lca_pkg::DIST_W-1:0];
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            i_reg        <= '0;
            n_reg        <= '0;
            j_reg        <= '0;
            top_reg      <= '0;
            lvl_reg      <= '0;
            k_reg        <= '0;
            u_reg        <= '0;
            v_reg        <= '0;
            pu_reg       <= '0;
            anc_reg      <= '0;
            du_reg       <= '0;
            dv_reg       <= '0;
            gap_reg      <= '0;
            sum_reg      <= '0;
            flat_reg     <= 1'b0;
            ancestor_reg <= '0;
            distance_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            done_reg     <= done_next;
            i_reg        <= i_next;
            n_reg        <= n_next;
            j_reg        <= j_next;
            top_reg      <= top_next;
            lvl_reg      <= lvl_next;
            k_reg        <= k_next;
            u_reg        <= u_next;
            v_reg        <= v_next;
            pu_reg       <= pu_next;
            anc_reg      <= anc_next;
            du_reg       <= du_next;
            dv_reg       <= dv_next;
            gap_reg      <= gap_next;
            sum_reg      <= sum_next;
            flat_reg     <= flat_next;
            ancestor_reg <= ancestor_next;
            distance_reg <= distance_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign ancestor = ancestor_reg;
    assign distance = distance_reg;

endmodule

// ===== hw/rtl/tree_lca_binary_lifting_core.sv =====
// Lowest common ancestor engine over a rooted tree, by binary lifting.
// Command channel: an item is taken when start is high and busy is low.
//   action load  : stores parent (jump level 0) and depth of node_a.
//   action build : fills jump levels 1..min(floor(log2(n)), LEVELS) for
//                  nodes 1..n, n = min(node_count, MAX_NODES); each table
//                  entry takes a second read (S_B_RD2) and a write (S_B_WR).
//   action query : one beat on ancestor/distance, marked by done for a single
//                  cycle. The jump table memory has one read port, so the
//                  lifting steps read it one at a time.
// Only one item is in flight; busy stays high until it has finished.
// Results cannot be held off: done is a strobe and the receiver must take it.
// node_count sits at byte address 0 of the APB port, reset value 1; write it
// only while busy is low.
// After reset both stores are swept to zero, one entry per cycle, over all
// (MAX_NODES+1)*(LEVELS+1) jump table entries (11264 by default); busy is high meanwhile.
module tree_lca_binary_lifting_core #(
    parameter int MAX_NODES = 1023,
    parameter int LEVELS    = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lca_pkg::ACT_W-1:0]     action,
    input  logic [lca_pkg::NODE_W-1:0]    node_a,
    input  logic [lca_pkg::NODE_W-1:0]    node_b,
    input  logic [lca_pkg::DEPTH_W-1:0]   node_depth,
    output logic                          done,
    output logic [lca_pkg::NODE_W-1:0]    ancestor,
    output logic [lca_pkg::DIST_W-1:0]    distance,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int ROWS  = MAX_NODES + 1;
    localparam int TOTAL = ROWS * (LEVELS + 1);
    localparam int AW    = $clog2(ROWS);
    localparam int JW    = $clog2(TOTAL);
    localparam int SW    = lca_pkg::alu_width(LEVELS);

    logic [lca_pkg::CNT_W-1:0]    node_count_reg, node_count_next;

    logic                         jt_we;
    logic [JW-1:0]                jt_waddr;
    logic [lca_pkg::NODE_W-1:0]   jt_wdata;
    logic [JW-1:0]                jt_raddr;
    logic [lca_pkg::NODE_W-1:0]   jt_rdata;
    logic                         dp_we;
    logic [AW-1:0]                dp_waddr;
    logic [lca_pkg::DEPTH_W-1:0]  dp_wdata;
    logic [AW-1:0]                dp_raddr;
    logic [lca_pkg::DEPTH_W-1:0]  dp_rdata;
    lca_pkg::alu_ctl_t            alu_ctl;
    logic signed [SW-1:0]         alu_a;
    logic signed [SW-1:0]         alu_b;
    logic signed [SW-1:0]         alu_res;
    lca_pkg::alu_flags_t          alu_flags;

    // register decode on the word address only
    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && pready && !paddr[2])
        begin
            node_count_next = pwdata[lca_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= lca_pkg::CNT_W'(1);
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(node_count_reg);
    assign pready = 1'b1;

    lca_seq #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .node_a     (node_a),
        .node_b     (node_b),
        .node_depth (node_depth),
        .node_count (node_count_reg),
        .busy       (busy),
        .done       (done),
        .ancestor   (ancestor),
        .distance   (distance),
        .jt_we      (jt_we),
        .jt_waddr   (jt_waddr),
        .jt_wdata   (jt_wdata),
        .jt_raddr   (jt_raddr),
        .jt_rdata   (jt_rdata),
        .dp_we      (dp_we),
        .dp_waddr   (dp_waddr),
        .dp_wdata   (dp_wdata),
        .dp_raddr   (dp_raddr),
        .dp_rdata   (dp_rdata),
        .alu_ctl    (alu_ctl),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_res    (alu_res),
        .alu_flags  (alu_flags)
    );

    lca_alu #(
        .W (SW)
    ) u_alu (
        .ctl   (alu_ctl),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    lca_ram #(
        .DEPTH (TOTAL),
        .DW    (lca_pkg::NODE_W)
    ) u_jump_ram (
        .clk   (clk),
        .we    (jt_we),
        .waddr (jt_waddr),
        .wdata (jt_wdata),
        .raddr (jt_raddr),
        .rdata (jt_rdata)
    );

    lca_ram #(
        .DEPTH (ROWS),
        .DW    (lca_pkg::DEPTH_W)
    ) u_depth_ram (
        .clk   (clk),
        .we    (dp_we),
        .waddr (dp_waddr),
        .wdata (dp_wdata),
        .raddr (dp_raddr),
        .rdata (dp_rdata)
    );

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an item in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == lca_pkg::ACT_QUERY) |=> busy)
        else $error("query taken but engine not busy");

endmodule

// ===== bench/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES   = 1023;
    localparam int LEVELS      = 10;
    localparam int ITEM_TARGET = 1200;

    localparam logic [lca_pkg::ACT_W-1:0] ACT_UNUSED      = 2'd3;
    localparam logic [2:0]                NODE_COUNT_ADDR = 3'd0;

    typedef struct packed {
        logic [lca_pkg::ACT_W-1:0]   act;
        logic [lca_pkg::NODE_W-1:0]  a;
        logic [lca_pkg::NODE_W-1:0]  b;
        logic [lca_pkg::DEPTH_W-1:0] dep;
    } lca_cmd_t;

    typedef struct packed {
        logic [lca_pkg::NODE_W-1:0] ancestor;
        logic [lca_pkg::DIST_W-1:0] distance;
    } lca_result_t;

    typedef enum int {SHAPE_RANDOM, SHAPE_CHAIN, SHAPE_BUSHY} shape_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [lca_pkg::ACT_W-1:0]     action;
    logic [lca_pkg::NODE_W-1:0]    node_a;
    logic [lca_pkg::NODE_W-1:0]    node_b;
    logic [lca_pkg::DEPTH_W-1:0]   node_depth;
    logic                          done;
    logic [lca_pkg::NODE_W-1:0]    ancestor;
    logic [lca_pkg::DIST_W-1:0]    distance;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // shadow of the block's stores and register
    logic [lca_pkg::NODE_W-1:0]  anc_table [0:MAX_NODES][0:LEVELS];
    logic [lca_pkg::DEPTH_W-1:0] node_level [0:MAX_NODES];
    logic [lca_pkg::CNT_W-1:0]   cfg_nodes;

    lca_result_t lca_expected[$];

    int gen_label [1:MAX_NODES];
    int gen_depth [1:MAX_NODES];

    int n_err      = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_builds   = 0;
    int n_settings = 0;
    int calm_left  = 0;

    tree_lca_binary_lifting_core #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .node_a     (node_a),
        .node_b     (node_b),
        .node_depth (node_depth),
        .done       (done),
        .ancestor   (ancestor),
        .distance   (distance),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // -1 for zero, as the lifting loops must not run then
    function automatic int log2_floor(input int x);
        int r;
        r = -1;
        while (x != 0)
        begin
            x = x >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic lca_result_t predict_lca(input int qa, input int qb);
        int u, v, t, k, i, pu, pv, anc, span;
        lca_result_t r;
        u = (qa > MAX_NODES) ? 0 : qa;
        v = (qb > MAX_NODES) ? 0 : qb;
        if (node_level[u] < node_level[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        k = log2_floor(node_level[u]);
        if (k > LEVELS)
        begin
            k = LEVELS;
        end
        for (i = k; i >= 0; i--)
        begin
            if (int'(node_level[u]) - (1 << i) >= int'(node_level[v]))
            begin
                u = anc_table[u][i];
            end
        end
        if (u == v)
        begin
            anc = u;
        end
        else
        begin
            for (i = k; i >= 0; i--)
            begin
                pu = anc_table[u][i];
                pv = anc_table[v][i];
                if (pu != 0 && pu != pv)
                begin
                    u = pu;
                    v = pv;
                end
            end
            anc = anc_table[u][0];
        end
        span = int'(node_level[(qa > MAX_NODES) ? 0 : qa])
             + int'(node_level[(qb > MAX_NODES) ? 0 : qb])
             - 2 * int'(node_level[anc]);
        if (span < 0)
        begin
            span = 0;
        end
        if (span > lca_pkg::DIST_MAX)
        begin
            span = lca_pkg::DIST_MAX;
        end
        r.ancestor = lca_pkg::NODE_W'(anc);
        r.distance = lca_pkg::DIST_W'(span);
        return r;
    endfunction

    task automatic advance_tree_model(input lca_cmd_t c);
        int n, top, i, j;
        case (c.act)
            lca_pkg::ACT_LOAD:
            begin
                if (c.a != 0 && c.a <= MAX_NODES)
                begin
                    anc_table[c.a][0] = (c.b > MAX_NODES) ? '0 : c.b;
                    node_level[c.a]   = c.dep;
                end
            end
            lca_pkg::ACT_BUILD:
            begin
                n   = (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
                top = log2_floor(n);
                if (top > LEVELS)
                begin
                    top = LEVELS;
                end
                for (j = 1; j <= top; j++)
                begin
                    for (i = 1; i <= n; i++)
                    begin
                        anc_table[i][j] = anc_table[anc_table[i][j-1]][j-1];
                    end
                end
            end
            lca_pkg::ACT_QUERY:
            begin
                lca_expected = {lca_expected, predict_lca(c.a, c.b)};
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic lca_cmd_t make_cmd(input logic [lca_pkg::ACT_W-1:0] act,
                                          input int a, input int b, input int dep);
        lca_cmd_t c;
        c.act = act;
        c.a   = lca_pkg::NODE_W'(a);
        c.b   = lca_pkg::NODE_W'(b);
        c.dep = lca_pkg::DEPTH_W'(dep);
        return c;
    endfunction

    function automatic lca_cmd_t noise_cmd();
        case ($urandom_range(0, 3))
            0:       return make_cmd(ACT_UNUSED, $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023));
            1:       return make_cmd(lca_pkg::ACT_LOAD, 0, $urandom_range(0, 1023),
                                     $urandom_range(0, 1023));
            2:       return make_cmd(lca_pkg::ACT_QUERY, $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023));
            default: return make_cmd(lca_pkg::ACT_LOAD, $urandom_range(1, MAX_NODES),
                                     $urandom_range(0, 1023), $urandom_range(0, 1023));
        endcase
    endfunction

    // mostly back to back or short, a few long gaps, and now and then a calm run
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input lca_cmd_t c);
        int gap;
        start      <= 1'b1;
        action     <= c.act;
        node_a     <= c.a;
        node_b     <= c.b;
        node_depth <= c.dep;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        advance_tree_model(c);
        if (c.act != ACT_UNUSED && !(c.act == lca_pkg::ACT_LOAD && c.a == 0))
        begin
            n_items++;
        end
        if (c.act == lca_pkg::ACT_BUILD)
        begin
            n_builds++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // loads and builds give no beat, so busy has to be low as well
    task automatic drain();
        start <= 1'b0;
        while (lca_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_node_count();
        logic [31:0] got;
        apb_read(NODE_COUNT_ADDR, got);
        if (got !== {22'd0, cfg_nodes})
        begin
            $display("%0t: node_count read back: expected %0d, actual %0d",
                     $time, cfg_nodes, got);
            n_err++;
        end
    endtask

    task automatic set_node_count(input int value);
        logic [31:0] wdata;
        drain();
        wdata      = $urandom();
        wdata[9:0] = value[9:0];
        apb_write(NODE_COUNT_ADDR, wdata);
        cfg_nodes = wdata[9:0];
        n_settings++;
        // an idle wait between the write and the read-back
        @(posedge clk);
        check_node_count();
    endtask

    // Loads a tree with shuffled node numbers, builds it (mostly) and queries it.
    task automatic run_tree_phase(input int n, input shape_t shape, input int n_q,
                                  input int count, input bit always_build);
        int i, j, t, p, r, qa, qb;
        set_node_count(count);
        for (i = 1; i <= n; i++)
        begin
            gen_label[i] = i;
        end
        for (i = n; i >= 2; i--)
        begin
            j = $urandom_range(1, i);
            t = gen_label[i];
            gen_label[i] = gen_label[j];
            gen_label[j] = t;
        end
        gen_depth[1] = 0;
        issue(make_cmd(lca_pkg::ACT_LOAD, gen_label[1], 0, 0));
        for (i = 2; i <= n; i++)
        begin
            case (shape)
                SHAPE_CHAIN: p = (i > 2 && $urandom_range(0, 19) == 0) ? i - 2 : i - 1;
                SHAPE_BUSHY: p = $urandom_range(1, (i - 1 < 4) ? i - 1 : 4);
                default:     p = $urandom_range(1, i - 1);
            endcase
            gen_depth[i] = gen_depth[p] + 1;
            if ($urandom_range(0, 99) < 3)
            begin
                issue(noise_cmd());
            end
            issue(make_cmd(lca_pkg::ACT_LOAD, gen_label[i], gen_label[p], gen_depth[i]));
        end
        // now and then the queries run against a stale table
        if (always_build || $urandom_range(0, 9) != 0)
        begin
            issue(make_cmd(lca_pkg::ACT_BUILD, $urandom_range(0, 1023),
                           $urandom_range(0, 1023), $urandom_range(0, 1023)));
        end
        for (i = 0; i < n_q; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                issue(noise_cmd());
            end
            else
            begin
                qa = gen_label[$urandom_range(1, n)];
                qb = gen_label[$urandom_range(1, n)];
                if (r < 14)
                begin
                    qb = $urandom_range(0, MAX_NODES);
                end
                else if (r < 20)
                begin
                    qb = qa;
                end
                issue(make_cmd(lca_pkg::ACT_QUERY, qa, qb, $urandom_range(0, 1023)));
            end
        end
    endtask

    task automatic test_reset_state();
        drain();
        check_node_count();
        issue(make_cmd(lca_pkg::ACT_QUERY, 0, 0, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 1023, 517, 1022));
    endtask

    task automatic test_ignored_items();
        issue(make_cmd(ACT_UNUSED, 1023, 1023, 1023));
        issue(make_cmd(lca_pkg::ACT_LOAD, 0, 9, 5));
        issue(make_cmd(lca_pkg::ACT_QUERY, 0, 0, 0));
    endtask

    task automatic test_small_tree();
        issue(make_cmd(lca_pkg::ACT_LOAD, 1, 0, 0));
        issue(make_cmd(lca_pkg::ACT_LOAD, 2, 1, 1));
        issue(make_cmd(lca_pkg::ACT_LOAD, 3, 1, 1));
        issue(make_cmd(lca_pkg::ACT_LOAD, 4, 2, 2));
        issue(make_cmd(lca_pkg::ACT_LOAD, 5, 4, 3));
        // only level 0 present yet
        issue(make_cmd(lca_pkg::ACT_QUERY, 5, 3, 0));
        set_node_count(5);
        issue(make_cmd(lca_pkg::ACT_BUILD, 0, 0, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 5, 3, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 4, 5, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 2, 2, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 3, 0, 0));
    endtask

    task automatic test_inconsistent_depths();
        // ancestor deeper than both nodes: distance clamps at zero
        issue(make_cmd(lca_pkg::ACT_LOAD, 6, 5, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 6, 1, 0));
        // two unrelated nodes at depth 1022: a large distance
        issue(make_cmd(lca_pkg::ACT_LOAD, 1023, 1022, 1022));
        issue(make_cmd(lca_pkg::ACT_LOAD, 1021, 0, 1022));
        issue(make_cmd(lca_pkg::ACT_QUERY, 1023, 1021, 0));
    endtask

    task automatic test_build_sizes();
        set_node_count(0);
        issue(make_cmd(lca_pkg::ACT_BUILD, 0, 0, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 5, 3, 0));
        set_node_count(1);
        issue(make_cmd(lca_pkg::ACT_BUILD, 0, 0, 0));
        issue(make_cmd(lca_pkg::ACT_QUERY, 1023, 6, 0));
    endtask

    // deep enough that the top lifting level is used
    task automatic test_deep_chain();
        run_tree_phase(640, SHAPE_CHAIN, 100, MAX_NODES, 1'b1);
    endtask

    task automatic test_random_trees();
        int n, cnt, r;
        shape_t shape;
        while (n_items < ITEM_TARGET)
        begin
            n     = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 150)
                                                : $urandom_range(2, 40);
            shape = shape_t'($urandom_range(0, 2));
            r     = $urandom_range(0, 19);
            if (r == 0)
            begin
                cnt = $urandom_range(n, MAX_NODES);
            end
            else if (r == 1)
            begin
                cnt = $urandom_range(0, n);
            end
            else
            begin
                cnt = n;
            end
            run_tree_phase(n, shape, $urandom_range(15, 40), cnt, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        lca_result_t want;
        if (rst_n && done)
        begin
            if (lca_expected.size() == 0)
            begin
                $display("%0t: unexpected result: ancestor %0d distance %0d",
                         $time, ancestor, distance);
                n_err++;
            end
            else
            begin
                want = lca_expected.pop_front();
                n_checked++;
                if (ancestor !== want.ancestor)
                begin
                    $display("%0t: ancestor: expected %0d, actual %0d",
                             $time, want.ancestor, ancestor);
                    n_err++;
                end
                if (distance !== want.distance)
                begin
                    $display("%0t: distance: expected %0d, actual %0d",
                             $time, want.distance, distance);
                    n_err++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main
        int i, j, w;
        for (i = 0; i <= MAX_NODES; i++)
        begin
            node_level[i] = '0;
            for (j = 0; j <= LEVELS; j++)
            begin
                anc_table[i][j] = '0;
            end
        end
        cfg_nodes  = 10'd1;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= '0;
        node_a     <= '0;
        node_b     <= '0;
        node_depth <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_ignored_items();
        test_small_tree();
        test_inconsistent_depths();
        test_build_sizes();
        test_deep_chain();
        test_random_trees();

        start <= 1'b0;
        for (w = 0; w < 4000 && lca_expected.size() != 0; w++)
        begin
            @(posedge clk);
        end
        if (lca_expected.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, lca_expected.size());
            n_err += lca_expected.size();
        end
        repeat (2) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        $display("Ran %0d commands: %0d tree queries checked, %0d table builds,",
                 n_items, n_checked, n_builds);
        $display("%0d node_count settings, trees from 2 to 640 nodes.", n_settings);
        if (n_err == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lca_pkg.sv
hw/rtl/lca_ram.sv
hw/rtl/lca_alu.sv
hw/rtl/lca_seq.sv
hw/rtl/tree_lca_binary_lifting_core.sv
bench/testbench.sv
